// File: design/lbad_pkg.sv
// Shared types, constants and codes of the bus arbiter with address decoder.
`timescale 1ns / 1ps
package lbad_pkg;

   localparam int MASTER_COUNT = 4;
   localparam int SLAVE_COUNT  = 4;
   localparam int BUS_WIDTH    = 16;

   localparam int LANE_COUNT   = 4;   // lanes in the packed master fields
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LANE_COUNT-1:0] MASTER_MASK = LANE_COUNT'((1 << MASTER_COUNT) - 1);

   // Configuration register indexes.
   localparam logic [3:0] CSR_SLAVE0_BASE = 4'd0;
   localparam logic [3:0] CSR_SLAVE0_SIZE = 4'd1;
   localparam logic [3:0] CSR_SLAVE1_BASE = 4'd2;
   localparam logic [3:0] CSR_SLAVE1_SIZE = 4'd3;
   localparam logic [3:0] CSR_SLAVE2_BASE = 4'd4;
   localparam logic [3:0] CSR_SLAVE2_SIZE = 4'd5;
   localparam logic [3:0] CSR_SLAVE3_BASE = 4'd6;
   localparam logic [3:0] CSR_SLAVE3_SIZE = 4'd7;

   typedef enum logic {
      CMD_REQUEST = 1'b0,
      CMD_READY   = 1'b1
   } cmd_type;

   typedef enum logic {
      KIND_ISSUE = 1'b0,
      KIND_DONE  = 1'b1
   } kind_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [3:0]  read_mask;
      logic [3:0]  write_mask;
      logic [63:0] master_addresses;
      logic [63:0] master_write_data;
      logic [1:0]  ready_slave;
      logic [15:0] slave_read_data;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [1:0]  granted_master;
      logic [1:0]  selected_slave;
      logic        decode_hit;
      logic [15:0] local_address;
      logic        read_strobe;
      logic        write_strobe;
      logic [15:0] slave_write_data;
      logic [15:0] master_read_data;
   } rsp_type;

   // Window decode of one master's address.
   typedef struct packed {
      logic [1:0]  sel;
      logic        hit;
      logic [15:0] local_address;
   } dec_type;

   // A classified event as it waits in the queue.
   typedef struct packed {
      cmd_type                        cmd;
      logic [LANE_COUNT-1:0]          req;
      logic [LANE_COUNT-1:0]          read_mask;
      logic [LANE_COUNT-1:0]          write_mask;
      logic [LANE_COUNT-1:0][15:0]    write_data;
      dec_type [LANE_COUNT-1:0]       dec;
      logic [1:0]                     ready_slave;
      logic [15:0]                    slave_read_data;
   } entry_type;

endpackage

// File: design/lru_bus_arbiter_address_decoder_top.sv
// Top level of the least-recently-granted bus arbiter with address decoder.
// Usage:
//   req_*  carries bus events: a request round (read and write masks with the
//          masters' packed addresses and write data) or a slave-ready report.
//   rsp_*  carries at most one result per event: an access issued to a slave
//          (kind issue) or an access completed back to its master (kind done).
//   csr_*  writes the base and size of each slave window; csr_ready is always
//          high and a transfer to an index past the last register is dropped.
// Path: an accepted event is decoded and written into the queue; from the
//   queue head it is arbitrated into the result register, which drives
//   rsp_valid; a stall holds it in the queue.
// Throughput: one event per cycle while the result register is free or taken,
//   set by the single back-end arbitration step, also taken by no-result events.
// Reset: synchronous and active high; clears windows to zero, the priority
//   list to masters 0..3, the busy flag, the owner, the queue and rsp_valid.
// Stall: while rsp_ready is low one result is held, the two-entry queue
//   fills, and req_ready drops once it is full.
`timescale 1ns / 1ps
module lru_bus_arbiter_address_decoder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lbad_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lbad_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_index,
   input  logic [15:0]       csr_data
);

   lbad_pkg::entry_type push_entry;
   lbad_pkg::entry_type head_entry;
   logic                head_valid;
   logic                head_ready;

   assign csr_ready = 1'b1;

   lbad_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .entry     (push_entry)
   );

   lbad_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (push_entry),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_data   (head_entry)
   );

   lbad_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_ready (head_ready),
      .head       (head_entry),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// File: design/lbad_front.sv
// Front end: configuration registers and per-master address window decode.
`timescale 1ns / 1ps
module lbad_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [3:0]          csr_index,
   input  logic [15:0]         csr_data,
   input  lbad_pkg::req_type   req_data,
   output lbad_pkg::entry_type entry
);

   logic [lbad_pkg::SLAVE_COUNT-1:0][15:0] base_ff, base_in;
   logic [lbad_pkg::SLAVE_COUNT-1:0][15:0] size_ff, size_in;

   always_comb begin
      base_in = base_ff;
      size_in = size_ff;
      if (csr_write) begin
         unique case (csr_index)
            lbad_pkg::CSR_SLAVE0_BASE: base_in[0] = csr_data;
            lbad_pkg::CSR_SLAVE0_SIZE: size_in[0] = csr_data;
            lbad_pkg::CSR_SLAVE1_BASE: begin
               if (lbad_pkg::SLAVE_COUNT > 1) base_in[1 % lbad_pkg::SLAVE_COUNT] = csr_data;
            end
            lbad_pkg::CSR_SLAVE1_SIZE: begin
               if (lbad_pkg::SLAVE_COUNT > 1) size_in[1 % lbad_pkg::SLAVE_COUNT] = csr_data;
            end
            lbad_pkg::CSR_SLAVE2_BASE: begin
               if (lbad_pkg::SLAVE_COUNT > 2) base_in[2 % lbad_pkg::SLAVE_COUNT] = csr_data;
            end
            lbad_pkg::CSR_SLAVE2_SIZE: begin
               if (lbad_pkg::SLAVE_COUNT > 2) size_in[2 % lbad_pkg::SLAVE_COUNT] = csr_data;
            end
            lbad_pkg::CSR_SLAVE3_BASE: begin
               if (lbad_pkg::SLAVE_COUNT > 3) base_in[3 % lbad_pkg::SLAVE_COUNT] = csr_data;
            end
            lbad_pkg::CSR_SLAVE3_SIZE: begin
               if (lbad_pkg::SLAVE_COUNT > 3) size_in[3 % lbad_pkg::SLAVE_COUNT] = csr_data;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         size_ff <= '0;
      end else begin
         base_ff <= base_in;
         size_ff <= size_in;
      end
   end

   // The window decode depends only on the address and the configuration, so
   // every master's lane is decoded here before arbitration picks one.
   always_comb begin
      logic [lbad_pkg::BUS_WIDTH-1:0] addr;
      logic [lbad_pkg::BUS_WIDTH-1:0] b;
      logic [lbad_pkg::BUS_WIDTH-1:0] sz;
      logic [lbad_pkg::BUS_WIDTH:0]   top;
      logic                           found;
      logic [1:0]                     sel;
      logic [lbad_pkg::BUS_WIDTH-1:0] sel_base;
      entry.cmd             = req_data.cmd;
      entry.req             = (req_data.read_mask | req_data.write_mask) & lbad_pkg::MASTER_MASK;
      entry.read_mask       = req_data.read_mask;
      entry.write_mask      = req_data.write_mask;
      entry.ready_slave     = req_data.ready_slave;
      entry.slave_read_data = req_data.slave_read_data;
      for (int m = 0; m < lbad_pkg::LANE_COUNT; m++) begin
         entry.write_data[m] =
            16'(req_data.master_write_data[16*m +: 16] & 16'((1 << lbad_pkg::BUS_WIDTH) - 1));
         addr  = req_data.master_addresses[16*m +: lbad_pkg::BUS_WIDTH];
         found = 1'b0;
         sel   = 2'd0;
         for (int s = 0; s < lbad_pkg::SLAVE_COUNT; s++) begin
            b   = base_ff[s][lbad_pkg::BUS_WIDTH-1:0];
            sz  = size_ff[s][lbad_pkg::BUS_WIDTH-1:0];
            top = {1'b0, b} + {1'b0, sz};
            if (!found && addr >= b && {1'b0, addr} < top) begin
               found = 1'b1;
               sel   = 2'(s);
            end
         end
         sel_base                   = base_ff[sel][lbad_pkg::BUS_WIDTH-1:0];
         entry.dec[m].sel           = sel;
         entry.dec[m].hit           = found;
         entry.dec[m].local_address = 16'(addr - sel_base);
      end
   end

endmodule

// File: design/lbad_queue.sv
// Short queue of classified events between the front end and the arbiter.
`timescale 1ns / 1ps
module lbad_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  lbad_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output lbad_pkg::entry_type pop_data
);

   lbad_pkg::entry_type              mem_ff [lbad_pkg::QUEUE_DEPTH];
   logic [lbad_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [lbad_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [lbad_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             push, pop;

   assign push_ready = (count_ff != lbad_pkg::QCNT_W'(lbad_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == lbad_pkg::QPTR_W'(lbad_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == lbad_pkg::QPTR_W'(lbad_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + lbad_pkg::QCNT_W'(push) - lbad_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/lbad_back.sv
// Back end: least-recently-granted arbitration, bus ownership and result register.
`timescale 1ns / 1ps
module lbad_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   output logic                head_ready,
   input  lbad_pkg::entry_type head,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lbad_pkg::rsp_type   rsp_data
);

   logic [lbad_pkg::MASTER_COUNT-1:0][1:0] order_ff, order_in;
   logic                                   busy_ff, busy_in;
   logic [1:0]                             owner_master_ff, owner_master_in;
   logic [1:0]                             owner_slave_ff, owner_slave_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   lbad_pkg::rsp_type                      rsp_data_ff, rsp_data_in;

   logic                                   advance;
   logic                                   found;
   logic [1:0]                             pos;
   logic [1:0]                             winner;
   logic                                   produce;
   lbad_pkg::rsp_type                      result;

   // The result register frees up in the same cycle it is taken.
   assign advance    = head_valid && (!rsp_valid_ff || rsp_ready);
   assign head_ready = advance;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // First requester in the priority list.
   always_comb begin
      found  = 1'b0;
      pos    = 2'd0;
      winner = 2'd0;
      for (int i = 0; i < lbad_pkg::MASTER_COUNT; i++) begin
         if (!found && head.req[order_ff[i]]) begin
            found  = 1'b1;
            pos    = 2'(i);
            winner = order_ff[i];
         end
      end
   end

   always_comb begin
      order_in        = order_ff;
      busy_in         = busy_ff;
      owner_master_in = owner_master_ff;
      owner_slave_in  = owner_slave_ff;
      produce         = 1'b0;
      result          = '0;
      if (advance) begin
         unique case (head.cmd)
            lbad_pkg::CMD_REQUEST: begin
               if (!busy_ff && found) begin
                  // The winner moves to the back; those behind it move up one.
                  for (int j = 0; j < lbad_pkg::MASTER_COUNT - 1; j++) begin
                     if (j >= int'(pos)) begin
                        order_in[j] = order_ff[j + 1];
                     end
                  end
                  order_in[lbad_pkg::MASTER_COUNT - 1] = winner;
                  busy_in                  = 1'b1;
                  owner_master_in          = winner;
                  owner_slave_in           = head.dec[winner].sel;
                  produce                  = 1'b1;
                  result.kind              = lbad_pkg::KIND_ISSUE;
                  result.granted_master    = winner;
                  result.selected_slave    = head.dec[winner].sel;
                  result.decode_hit        = head.dec[winner].hit;
                  result.local_address     = head.dec[winner].local_address;
                  result.read_strobe       = head.read_mask[winner];
                  result.write_strobe      = head.write_mask[winner];
                  result.slave_write_data  = head.write_data[winner];
               end
            end
            lbad_pkg::CMD_READY: begin
               if (busy_ff && head.ready_slave == owner_slave_ff) begin
                  busy_in                 = 1'b0;
                  produce                 = 1'b1;
                  result.kind             = lbad_pkg::KIND_DONE;
                  result.granted_master   = owner_master_ff;
                  result.selected_slave   = owner_slave_ff;
                  result.master_read_data =
                     head.slave_read_data & 16'((1 << lbad_pkg::BUS_WIDTH) - 1);
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_in = produce;
      end
      if (produce) begin
         rsp_data_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lbad_pkg::MASTER_COUNT; i++) begin
            order_ff[i] <= 2'(i);
         end
         busy_ff         <= 1'b0;
         owner_master_ff <= 2'd0;
         owner_slave_ff  <= 2'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         order_ff        <= order_in;
         busy_ff         <= busy_in;
         owner_master_ff <= owner_master_in;
         owner_slave_ff  <= owner_slave_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
